### rtl/go_to_goal_drive_command_top_defines.svh
// Assertion macros for the go-to-goal drive command block.
// Included by the top level; needs no other file.
`ifndef GO_TO_GOAL_DRIVE_COMMAND_TOP_DEFINES_SVH
`define GO_TO_GOAL_DRIVE_COMMAND_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define GTG_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("go_to_goal_drive_command: assertion failed");
// Next-cycle implication, checked at every rising clock edge out of reset.
`define GTG_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("go_to_goal_drive_command: assertion failed");
`else
`define GTG_ASSERT_IMP(label, clk, rstn, ante, cons)
`define GTG_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/gtg_pkg.sv
// Shared constants, register codes, side-band types and the CORDIC angle table.
// Depends on nothing; used by the two CORDIC modules, the top level and the testbench.
package gtg_pkg;

    localparam int POS_FRAC_BITS_DEF = 11;
    localparam int CORDIC_STAGES_DEF = 14;
    localparam int ATAN_LEN          = 24;

    // Angles in Q3.13.
    localparam logic signed [16:0] PI_Q13       = 17'sd25736;
    localparam logic signed [16:0] NEG_PI_Q13   = -17'sd25736;
    localparam logic signed [16:0] TWO_PI_Q13   = 17'sd51472;
    localparam logic signed [16:0] HALF_PI_Q13  = 17'sd12868;
    localparam logic signed [16:0] NEG_HALF_Q13 = -17'sd12868;

    // CORDIC datapath in Q16.
    localparam int ANG_W = 20;
    localparam logic signed [ANG_W-1:0] CORDIC_START = 20'sd39797;

    // Configuration register reset values.
    localparam logic [14:0] GOAL_X_RST   = 15'd0;
    localparam logic [14:0] GOAL_Y_RST   = 15'd0;
    localparam logic [7:0]  LIN_GAIN_RST = 8'd96;
    localparam logic [7:0]  ANG_GAIN_RST = 8'd96;
    localparam logic [14:0] LIMIT_RST    = 15'd16384;
    localparam logic [14:0] TOL_RST      = 15'd20;
    localparam logic [14:0] BAND_RST     = 15'd1024;

    typedef enum logic [2:0] {
        REG_GOAL_X       = 3'd0,
        REG_GOAL_Y       = 3'd1,
        REG_LINEAR_GAIN  = 3'd2,
        REG_ANGULAR_GAIN = 3'd3,
        REG_SPEED_LIMIT  = 3'd4,
        REG_ARRIVE_TOL   = 3'd5,
        REG_X_BAND       = 3'd6
    } cfg_reg_t;

    // Side band carried through the distance square root.
    typedef struct packed {
        logic signed [15:0]      dx;
        logic signed [15:0]      dy;
        logic signed [ANG_W-1:0] z;
        logic                    neg;
        logic                    rev;
    } sq_side_t;

    // Side band carried through the sine/cosine rotation.
    typedef struct packed {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [15:0]        dist_len;
        logic               neg;
        logic               rev;
        logic               arrived;
    } rot_side_t;

    // Side band carried through the ratio divider.
    typedef struct packed {
        logic        sign;
        logic        ovf;
        logic        dist_zero;
        logic [15:0] dist_len;
        logic        rev;
        logic        arrived;
    } div_side_t;

    // Side band carried through the second square root.
    typedef struct packed {
        logic signed [17:0] ratio;
        logic [15:0]        dist_len;
        logic               rev;
        logic               arrived;
    } rad_side_t;

    // Side band carried through the vectoring CORDIC.
    typedef struct packed {
        logic [15:0] dist_len;
        logic        rev;
        logic        arrived;
    } vec_side_t;

    // Arctangent of 2^-i in Q16, rounded.
    function automatic logic signed [ANG_W-1:0] atan_q16(input int idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            0:       val = 20'sd51472;
            1:       val = 20'sd30386;
            2:       val = 20'sd16055;
            3:       val = 20'sd8150;
            4:       val = 20'sd4091;
            5:       val = 20'sd2047;
            6:       val = 20'sd1024;
            7:       val = 20'sd512;
            8:       val = 20'sd256;
            9:       val = 20'sd128;
            10:      val = 20'sd64;
            11:      val = 20'sd32;
            12:      val = 20'sd16;
            13:      val = 20'sd8;
            14:      val = 20'sd4;
            15:      val = 20'sd2;
            16:      val = 20'sd1;
            default: val = 20'sd0;
        endcase
        return val;
    endfunction

endpackage

### rtl/gtg_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Uses no package items; side-band data travels alongside each value.
module gtg_sqrt #(
    parameter int IN_W = 32,
    parameter int PW   = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_val,
    input  logic [PW-1:0]     in_side,
    output logic              out_valid,
    output logic [IN_W/2-1:0] out_root,
    output logic [PW-1:0]     out_side
);
    localparam int N = IN_W / 2;

    logic [IN_W-1:0] v_reg    [1:N];
    logic [IN_W-1:0] r_reg    [1:N];
    logic [PW-1:0]   side_reg [1:N];
    logic            valid_reg[1:N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int BIT_POS = IN_W - 2 - 2 * k;
        localparam logic [IN_W:0] B = {{IN_W{1'b0}}, 1'b1} << BIT_POS;
        logic [IN_W-1:0] v_in, r_in, v_next, r_next;
        logic [PW-1:0]   s_in;
        logic            vl_in;
        logic [IN_W:0]   trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign v_in  = in_val;
            assign r_in  = '0;
            assign s_in  = in_side;
            assign vl_in = in_valid;
        end else begin : g_rest
            assign v_in  = v_reg[k];
            assign r_in  = r_reg[k];
            assign s_in  = side_reg[k];
            assign vl_in = valid_reg[k];
        end

        // Try to subtract the current bit pair; keep the partial root aligned.
        always_comb begin
            trial  = {1'b0, r_in} + B;
            ge     = {1'b0, v_in} >= trial;
            v_next = ge ? IN_W'({1'b0, v_in} - trial) : v_in;
            r_next = ge ? IN_W'(({1'b0, r_in} >> 1) + B) : (r_in >> 1);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= vl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[k+1]    <= v_next;
                r_reg[k+1]    <= r_next;
                side_reg[k+1] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_root  = r_reg[N][N-1:0];
    assign out_side  = side_reg[N];

endmodule

### rtl/gtg_cordic_rot.sv
// Pipelined rotation-mode CORDIC giving cosine and sine in Q16.
// Depends on gtg_pkg for the datapath width, start gain and angle table.
module gtg_cordic_rot #(
    parameter int STAGES = 14,
    parameter int PW     = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [gtg_pkg::ANG_W-1:0] in_z,
    input  logic [PW-1:0]                   in_side,
    output logic                            out_valid,
    output logic signed [gtg_pkg::ANG_W-1:0] out_cos,
    output logic signed [gtg_pkg::ANG_W-1:0] out_sin,
    output logic [PW-1:0]                   out_side
);
    localparam int W = gtg_pkg::ANG_W;

    logic signed [W-1:0] x_reg [1:STAGES];
    logic signed [W-1:0] y_reg [1:STAGES];
    logic signed [W-1:0] z_reg [1:STAGES];
    logic [PW-1:0]       side_reg [1:STAGES];
    logic                valid_reg[1:STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic signed [W-1:0] ANG = gtg_pkg::atan_q16(k);
        logic signed [W-1:0] x_in, y_in, z_in, x_next, y_next, z_next;
        logic [PW-1:0]       s_in;
        logic                vl_in;

        if (k == 0) begin : g_first
            assign x_in  = gtg_pkg::CORDIC_START;
            assign y_in  = '0;
            assign z_in  = in_z;
            assign s_in  = in_side;
            assign vl_in = in_valid;
        end else begin : g_rest
            assign x_in  = x_reg[k];
            assign y_in  = y_reg[k];
            assign z_in  = z_reg[k];
            assign s_in  = side_reg[k];
            assign vl_in = valid_reg[k];
        end

        // Rotate toward the residual angle by the micro-angle of this stage.
        always_comb begin
            if (!z_in[W-1]) begin
                x_next = x_in - (y_in >>> k);
                y_next = y_in + (x_in >>> k);
                z_next = z_in - ANG;
            end else begin
                x_next = x_in + (y_in >>> k);
                y_next = y_in - (x_in >>> k);
                z_next = z_in + ANG;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= vl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                z_reg[k+1]    <= z_next;
                side_reg[k+1] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_cos   = x_reg[STAGES];
    assign out_sin   = y_reg[STAGES];
    assign out_side  = side_reg[STAGES];

endmodule

### rtl/gtg_cordic_vec.sv
// Pipelined vectoring-mode CORDIC giving atan2(y, x) in Q16 for x >= 0.
// Depends on gtg_pkg for the datapath width and angle table.
module gtg_cordic_vec #(
    parameter int STAGES = 14,
    parameter int PW     = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [gtg_pkg::ANG_W-1:0] in_x,
    input  logic signed [gtg_pkg::ANG_W-1:0] in_y,
    input  logic [PW-1:0]                   in_side,
    output logic                            out_valid,
    output logic signed [gtg_pkg::ANG_W-1:0] out_angle,
    output logic [PW-1:0]                   out_side
);
    localparam int W = gtg_pkg::ANG_W;

    logic signed [W-1:0] x_reg [1:STAGES];
    logic signed [W-1:0] y_reg [1:STAGES];
    logic signed [W-1:0] z_reg [1:STAGES];
    logic [PW-1:0]       side_reg [1:STAGES];
    logic                valid_reg[1:STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic signed [W-1:0] ANG = gtg_pkg::atan_q16(k);
        logic signed [W-1:0] x_in, y_in, z_in, x_next, y_next, z_next;
        logic [PW-1:0]       s_in;
        logic                vl_in;

        if (k == 0) begin : g_first
            assign x_in  = in_x;
            assign y_in  = in_y;
            assign z_in  = '0;
            assign s_in  = in_side;
            assign vl_in = in_valid;
        end else begin : g_rest
            assign x_in  = x_reg[k];
            assign y_in  = y_reg[k];
            assign z_in  = z_reg[k];
            assign s_in  = side_reg[k];
            assign vl_in = valid_reg[k];
        end

        // Drive y toward zero and accumulate the angle turned through.
        always_comb begin
            if (!y_in[W-1]) begin
                x_next = x_in + (y_in >>> k);
                y_next = y_in - (x_in >>> k);
                z_next = z_in + ANG;
            end else begin
                x_next = x_in - (y_in >>> k);
                y_next = y_in + (x_in >>> k);
                z_next = z_in - ANG;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= vl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                z_reg[k+1]    <= z_next;
                side_reg[k+1] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_angle = z_reg[STAGES];
    assign out_side  = side_reg[STAGES];

endmodule

### rtl/gtg_div.sv
// Pipelined restoring divider, 34-bit dividend by 16-bit divisor, 17 quotient bits.
// Uses no package items; the caller checks quotient overflow beforehand.
module gtg_div #(
    parameter int PW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [33:0]   in_num,
    input  logic [15:0]   in_den,
    input  logic [PW-1:0] in_side,
    output logic          out_valid,
    output logic [16:0]   out_quot,
    output logic [PW-1:0] out_side
);
    localparam int QB = 17;

    logic [33:0]   rem_reg  [1:QB];
    logic [16:0]   quot_reg [1:QB];
    logic [15:0]   den_reg  [1:QB];
    logic [PW-1:0] side_reg [1:QB];
    logic          valid_reg[1:QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int BIT_POS = QB - 1 - k;
        logic [33:0]   rem_in, rem_next, den_sh;
        logic [16:0]   quot_in, quot_next;
        logic [15:0]   den_in;
        logic [PW-1:0] s_in;
        logic          vl_in;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = in_num;
            assign quot_in = '0;
            assign den_in  = in_den;
            assign s_in    = in_side;
            assign vl_in   = in_valid;
        end else begin : g_rest
            assign rem_in  = rem_reg[k];
            assign quot_in = quot_reg[k];
            assign den_in  = den_reg[k];
            assign s_in    = side_reg[k];
            assign vl_in   = valid_reg[k];
        end

        // One quotient bit: subtract the shifted divisor when it fits.
        always_comb begin
            den_sh    = {18'd0, den_in} << BIT_POS;
            ge        = rem_in >= den_sh;
            rem_next  = ge ? (rem_in - den_sh) : rem_in;
            quot_next = quot_in;
            quot_next[BIT_POS] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= vl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= rem_next;
                quot_reg[k+1] <= quot_next;
                den_reg[k+1]  <= den_in;
                side_reg[k+1] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign out_quot  = quot_reg[QB];
    assign out_side  = side_reg[QB];

endmodule

### rtl/go_to_goal_drive_command_top.sv
// Top level of the go-to-goal drive command pipeline and its configuration registers.
// Depends on gtg_pkg, gtg_sqrt, gtg_cordic_rot, gtg_div, gtg_cordic_vec and the defines header.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------------
//  s_       | in        | s_valid / s_ready    | s_pose_x, s_pose_y, s_pose_heading
//  m_       | out       | m_valid / m_ready    | m_linear_speed, m_turn_rate, m_arrived,
//           |           |                      | m_reversing
//  cfg_     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One pose sample enters per cycle unless the output stalls; the path runs through the two 16/17-stage
// square roots, the 17-stage divider and the two CORDIC chains, with registered stages between them.
// Reset clears all valid bits and loads the register defaults; there is no clearing pass.
// The whole pipeline advances together whenever the output register is empty or taken,
// so a stall holds every stage in place. Configuration writes are taken in every cycle.
`include "go_to_goal_drive_command_top_defines.svh"

module go_to_goal_drive_command_top #(
    parameter int POS_FRAC_BITS = gtg_pkg::POS_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [14:0]        s_pose_x,
    input  logic [14:0]        s_pose_y,
    input  logic signed [15:0] s_pose_heading,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_linear_speed,
    output logic signed [15:0] m_turn_rate,
    output logic               m_arrived,
    output logic               m_reversing,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [14:0]        cfg_data
);
    localparam int W          = gtg_pkg::ANG_W;
    localparam int TURN_SHIFT = 20 - POS_FRAC_BITS;
    localparam logic signed [28:0] TURN_RND = 29'((1 << TURN_SHIFT) >> 1);

    localparam int SQ_PW  = $bits(gtg_pkg::sq_side_t);
    localparam int ROT_PW = $bits(gtg_pkg::rot_side_t);
    localparam int DIV_PW = $bits(gtg_pkg::div_side_t);
    localparam int RAD_PW = $bits(gtg_pkg::rad_side_t);
    localparam int VEC_PW = $bits(gtg_pkg::vec_side_t);

    logic en;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [14:0] goal_x_reg, goal_y_reg, speed_limit_reg, tol_reg, band_reg;
    logic [7:0]  lin_gain_reg, ang_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg      <= gtg_pkg::GOAL_X_RST;
            goal_y_reg      <= gtg_pkg::GOAL_Y_RST;
            lin_gain_reg    <= gtg_pkg::LIN_GAIN_RST;
            ang_gain_reg    <= gtg_pkg::ANG_GAIN_RST;
            speed_limit_reg <= gtg_pkg::LIMIT_RST;
            tol_reg         <= gtg_pkg::TOL_RST;
            band_reg        <= gtg_pkg::BAND_RST;
        end else if (cfg_valid) begin
            case (gtg_pkg::cfg_reg_t'(cfg_index))
                gtg_pkg::REG_GOAL_X:       goal_x_reg      <= cfg_data;
                gtg_pkg::REG_GOAL_Y:       goal_y_reg      <= cfg_data;
                gtg_pkg::REG_LINEAR_GAIN:  lin_gain_reg    <= cfg_data[7:0];
                gtg_pkg::REG_ANGULAR_GAIN: ang_gain_reg    <= cfg_data[7:0];
                gtg_pkg::REG_SPEED_LIMIT:  speed_limit_reg <= cfg_data;
                gtg_pkg::REG_ARRIVE_TOL:   tol_reg         <= cfg_data;
                gtg_pkg::REG_X_BAND:       band_reg        <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage A: heading wrap, goal offsets and the drive direction rule.
    // ------------------------------------------------------------------
    logic               a_valid_reg;
    logic signed [15:0] a_dx_reg, a_dy_reg;
    logic signed [16:0] a_h_reg;
    logic               a_rev_reg;

    logic signed [15:0] a_dx_next, a_dy_next;
    logic signed [16:0] h_ext, h_w1, a_h_next;
    logic [16:0]        gx_plus;
    logic signed [17:0] gx_minus, px_s;
    logic               px_gt, px_lt, a_rev_next;

    always_comb begin
        h_ext     = {s_pose_heading[15], s_pose_heading};
        h_w1      = (h_ext > gtg_pkg::PI_Q13) ? (h_ext - gtg_pkg::TWO_PI_Q13) : h_ext;
        a_h_next  = (h_w1 < gtg_pkg::NEG_PI_Q13) ? (h_w1 + gtg_pkg::TWO_PI_Q13) : h_w1;
        a_dx_next = $signed({1'b0, goal_x_reg}) - $signed({1'b0, s_pose_x});
        a_dy_next = $signed({1'b0, goal_y_reg}) - $signed({1'b0, s_pose_y});
        gx_plus   = {2'b00, goal_x_reg} + {2'b00, band_reg};
        gx_minus  = $signed({3'b000, goal_x_reg}) - $signed({3'b000, band_reg});
        px_s      = $signed({3'b000, s_pose_x});
        px_gt     = {2'b00, s_pose_x} > gx_plus;
        px_lt     = px_s < gx_minus;
        if (px_gt) begin
            a_rev_next = (a_h_next > gtg_pkg::NEG_HALF_Q13) && (a_h_next < gtg_pkg::HALF_PI_Q13);
        end else if (px_lt) begin
            a_rev_next = (a_h_next > gtg_pkg::HALF_PI_Q13) || (a_h_next < gtg_pkg::NEG_HALF_Q13);
        end else if (s_pose_y >= goal_y_reg) begin
            a_rev_next = !a_h_next[16];
        end else begin
            a_rev_next = a_h_next[16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_dx_reg  <= a_dx_next;
            a_dy_reg  <= a_dy_next;
            a_h_reg   <= a_h_next;
            a_rev_reg <= a_rev_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: squared distance and the heading folded into +-pi/2.
    // ------------------------------------------------------------------
    logic                b_valid_reg;
    logic [31:0]         b_sq_reg;
    gtg_pkg::sq_side_t   b_side_reg;

    logic signed [31:0]  dx_e, dy_e;
    logic [31:0]         b_sq_next;
    logic signed [16:0]  z_fold;
    logic signed [W-1:0] z_ext;
    gtg_pkg::sq_side_t   b_side_next;

    always_comb begin
        dx_e      = 32'(a_dx_reg);
        dy_e      = 32'(a_dy_reg);
        b_sq_next = 32'(dx_e * dx_e) + 32'(dy_e * dy_e);
        b_side_next.neg = 1'b1;
        if (a_h_reg > gtg_pkg::HALF_PI_Q13) begin
            z_fold = a_h_reg - gtg_pkg::PI_Q13;
        end else if (a_h_reg < gtg_pkg::NEG_HALF_Q13) begin
            z_fold = a_h_reg + gtg_pkg::PI_Q13;
        end else begin
            z_fold = a_h_reg;
            b_side_next.neg = 1'b0;
        end
        z_ext          = W'(z_fold);
        b_side_next.z  = z_ext <<< 3;
        b_side_next.dx = a_dx_reg;
        b_side_next.dy = a_dy_reg;
        b_side_next.rev = a_rev_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_sq_reg   <= b_sq_next;
            b_side_reg <= b_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Distance square root.
    // ------------------------------------------------------------------
    logic              sq_out_valid;
    logic [15:0]       sq_root;
    logic [SQ_PW-1:0]  sq_side_in_vec, sq_side_out_vec;
    gtg_pkg::sq_side_t sq_side_out;

    assign sq_side_in_vec = b_side_reg;
    assign sq_side_out    = sq_side_out_vec;

    gtg_sqrt #(.IN_W(32), .PW(SQ_PW)) u_dist_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b_valid_reg),
        .in_val    (b_sq_reg),
        .in_side   (sq_side_in_vec),
        .out_valid (sq_out_valid),
        .out_root  (sq_root),
        .out_side  (sq_side_out_vec)
    );

    // ------------------------------------------------------------------
    // Sine and cosine of the folded heading; arrival decided on the way in.
    // ------------------------------------------------------------------
    gtg_pkg::rot_side_t  rot_side_in, rot_side_out;
    logic [ROT_PW-1:0]   rot_side_in_vec, rot_side_out_vec;
    logic                rot_out_valid;
    logic signed [W-1:0] rot_cos, rot_sin;

    always_comb begin
        rot_side_in.dx       = sq_side_out.dx;
        rot_side_in.dy       = sq_side_out.dy;
        rot_side_in.dist_len = sq_root;
        rot_side_in.neg      = sq_side_out.neg;
        rot_side_in.rev      = sq_side_out.rev;
        rot_side_in.arrived  = {1'b0, sq_root} < {2'b00, tol_reg};
    end

    assign rot_side_in_vec = rot_side_in;
    assign rot_side_out    = rot_side_out_vec;

    gtg_cordic_rot #(.STAGES(CORDIC_STAGES), .PW(ROT_PW)) u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_out_valid),
        .in_z      (sq_side_out.z),
        .in_side   (rot_side_in_vec),
        .out_valid (rot_out_valid),
        .out_cos   (rot_cos),
        .out_sin   (rot_sin),
        .out_side  (rot_side_out_vec)
    );

    // ------------------------------------------------------------------
    // Stage D: cross-product terms cos*dy and sin*dx.
    // ------------------------------------------------------------------
    logic               d_valid_reg;
    logic signed [35:0] d_p1_reg, d_p2_reg;
    gtg_pkg::rot_side_t d_side_reg;

    logic signed [W-1:0] c_f, s_f;
    logic signed [35:0]  c_e, s_e, dy_w, dx_w;

    always_comb begin
        c_f  = rot_side_out.neg ? -rot_cos : rot_cos;
        s_f  = rot_side_out.neg ? -rot_sin : rot_sin;
        c_e  = 36'(c_f);
        s_e  = 36'(s_f);
        dy_w = 36'(rot_side_out.dy);
        dx_w = 36'(rot_side_out.dx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= rot_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_p1_reg   <= c_e * dy_w;
            d_p2_reg   <= s_e * dx_w;
            d_side_reg <= rot_side_out;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: cross product.
    // ------------------------------------------------------------------
    logic               e_valid_reg;
    logic signed [36:0] e_num_reg;
    gtg_pkg::rot_side_t e_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_num_reg  <= 37'(d_p1_reg) - 37'(d_p2_reg);
            e_side_reg <= d_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: magnitude, sign and quotient overflow check for the divider.
    // ------------------------------------------------------------------
    logic               f_valid_reg;
    logic [33:0]        f_mag_reg;
    gtg_pkg::div_side_t f_side_reg;

    logic [36:0]        mag_full;
    gtg_pkg::div_side_t f_side_next;

    always_comb begin
        mag_full = e_num_reg[36] ? 37'(-e_num_reg) : 37'(e_num_reg);
        f_side_next.sign      = e_num_reg[36];
        f_side_next.ovf       = mag_full >= {4'b0000, e_side_reg.dist_len, 17'd0};
        f_side_next.dist_zero = e_side_reg.dist_len == 16'd0;
        f_side_next.dist_len  = e_side_reg.dist_len;
        f_side_next.rev       = e_side_reg.rev;
        f_side_next.arrived   = e_side_reg.arrived;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_mag_reg  <= mag_full[33:0];
            f_side_reg <= f_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Ratio divider.
    // ------------------------------------------------------------------
    logic               div_out_valid;
    logic [16:0]        div_quot;
    logic [DIV_PW-1:0]  div_side_in_vec, div_side_out_vec;
    gtg_pkg::div_side_t div_side_out;

    assign div_side_in_vec = f_side_reg;
    assign div_side_out    = div_side_out_vec;

    gtg_div #(.PW(DIV_PW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid_reg),
        .in_num    (f_mag_reg),
        .in_den    (f_side_reg.dist_len),
        .in_side   (div_side_in_vec),
        .out_valid (div_out_valid),
        .out_quot  (div_quot),
        .out_side  (div_side_out_vec)
    );

    // ------------------------------------------------------------------
    // Stage G: signed ratio clamped to [-1, 1] in Q16.
    // ------------------------------------------------------------------
    logic               g_valid_reg;
    gtg_pkg::rad_side_t g_side_reg;

    logic [16:0]        ratio_mag;
    logic signed [17:0] ratio_pos;
    gtg_pkg::rad_side_t g_side_next;

    always_comb begin
        if (div_side_out.dist_zero) begin
            ratio_mag = 17'd0;
        end else if (div_side_out.ovf || (div_quot > 17'd65536)) begin
            ratio_mag = 17'd65536;
        end else begin
            ratio_mag = div_quot;
        end
        ratio_pos            = $signed({1'b0, ratio_mag});
        g_side_next.ratio    = div_side_out.sign ? -ratio_pos : ratio_pos;
        g_side_next.dist_len = div_side_out.dist_len;
        g_side_next.rev      = div_side_out.rev;
        g_side_next.arrived  = div_side_out.arrived;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (en) begin
            g_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_side_reg <= g_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage H: radicand 2^32 - ratio^2 for the cosine leg.
    // ------------------------------------------------------------------
    logic               h_valid_reg;
    logic [33:0]        h_rad_reg;
    gtg_pkg::rad_side_t h_side_reg;

    logic signed [35:0] r_e, r_sq;

    always_comb begin
        r_e  = 36'(g_side_reg.ratio);
        r_sq = r_e * r_e;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
        end else if (en) begin
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_rad_reg  <= 34'h1_0000_0000 - r_sq[33:0];
            h_side_reg <= g_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Cosine-leg square root.
    // ------------------------------------------------------------------
    logic               rad_out_valid;
    logic [16:0]        rad_root;
    logic [RAD_PW-1:0]  rad_side_in_vec, rad_side_out_vec;
    gtg_pkg::rad_side_t rad_side_out;

    assign rad_side_in_vec = h_side_reg;
    assign rad_side_out    = rad_side_out_vec;

    gtg_sqrt #(.IN_W(34), .PW(RAD_PW)) u_rad_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (h_valid_reg),
        .in_val    (h_rad_reg),
        .in_side   (rad_side_in_vec),
        .out_valid (rad_out_valid),
        .out_root  (rad_root),
        .out_side  (rad_side_out_vec)
    );

    // ------------------------------------------------------------------
    // Heading error as atan2(ratio, sqrt(1 - ratio^2)).
    // ------------------------------------------------------------------
    gtg_pkg::vec_side_t  vec_side_in, vec_side_out;
    logic [VEC_PW-1:0]   vec_side_in_vec, vec_side_out_vec;
    logic                vec_out_valid;
    logic signed [W-1:0] vec_x, vec_y, vec_err;

    always_comb begin
        vec_x                = $signed({3'b000, rad_root});
        vec_y                = W'(rad_side_out.ratio);
        vec_side_in.dist_len = rad_side_out.dist_len;
        vec_side_in.rev      = rad_side_out.rev;
        vec_side_in.arrived  = rad_side_out.arrived;
    end

    assign vec_side_in_vec = vec_side_in;
    assign vec_side_out    = vec_side_out_vec;

    gtg_cordic_vec #(.STAGES(CORDIC_STAGES), .PW(VEC_PW)) u_vec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rad_out_valid),
        .in_x      (vec_x),
        .in_y      (vec_y),
        .in_side   (vec_side_in_vec),
        .out_valid (vec_out_valid),
        .out_angle (vec_err),
        .out_side  (vec_side_out_vec)
    );

    // ------------------------------------------------------------------
    // Stage J: gain products.
    // ------------------------------------------------------------------
    logic               j_valid_reg;
    logic [23:0]        j_lin_reg;
    logic signed [27:0] j_turn_reg;
    logic               j_rev_reg, j_arrived_reg;

    logic signed [27:0] ang_e, err_e;

    always_comb begin
        ang_e = $signed({20'd0, ang_gain_reg});
        err_e = 28'(vec_err);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_valid_reg <= 1'b0;
        end else if (en) begin
            j_valid_reg <= vec_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            j_lin_reg     <= {16'd0, lin_gain_reg} * {8'd0, vec_side_out.dist_len};
            j_turn_reg    <= ang_e * err_e;
            j_rev_reg     <= vec_side_out.rev;
            j_arrived_reg <= vec_side_out.arrived;
        end
    end

    // ------------------------------------------------------------------
    // Stage K: speed limit, rounding, direction and saturation into the output register.
    // ------------------------------------------------------------------
    logic               k_valid_reg;
    logic signed [15:0] k_lin_reg, k_turn_reg;
    logic               k_arrived_reg, k_rev_reg;

    logic [19:0]        gl;
    logic [14:0]        gl_lim;
    logic [15:0]        lin_pos, lin_val;
    logic signed [28:0] t_rnd, t_sh;
    logic signed [29:0] t_ext, t_sg;
    logic signed [15:0] turn_sat;

    always_comb begin
        gl      = j_lin_reg[23:4];
        gl_lim  = (gl > {5'd0, speed_limit_reg}) ? speed_limit_reg : gl[14:0];
        lin_pos = {1'b0, gl_lim};
        lin_val = j_rev_reg ? (16'd0 - lin_pos) : lin_pos;
        t_rnd   = 29'(j_turn_reg) + TURN_RND;
        t_sh    = t_rnd >>> TURN_SHIFT;
        t_ext   = 30'(t_sh);
        t_sg    = j_rev_reg ? -t_ext : t_ext;
        if (t_sg > 30'sd32767) begin
            turn_sat = 16'sd32767;
        end else if (t_sg < -30'sd32768) begin
            turn_sat = -16'sd32768;
        end else begin
            turn_sat = t_sg[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_valid_reg <= 1'b0;
        end else if (en) begin
            k_valid_reg <= j_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_arrived_reg <= j_arrived_reg;
            k_rev_reg     <= j_rev_reg && !j_arrived_reg;
            k_lin_reg     <= j_arrived_reg ? 16'sd0 : $signed(lin_val);
            k_turn_reg    <= j_arrived_reg ? 16'sd0 : turn_sat;
        end
    end

    // The pipeline moves as one whenever the output slot is free or being emptied.
    assign en             = !k_valid_reg || m_ready;
    assign s_ready        = en;
    assign m_valid        = k_valid_reg;
    assign m_linear_speed = k_lin_reg;
    assign m_turn_rate    = k_turn_reg;
    assign m_arrived      = k_arrived_reg;
    assign m_reversing    = k_rev_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `GTG_ASSERT_IMP(a_arrived_zero, aclk, aresetn, m_valid && m_arrived, (m_linear_speed == 16'sd0) && (m_turn_rate == 16'sd0) && !m_reversing)
    `GTG_ASSERT_IMP(a_fwd_sign, aclk, aresetn, m_valid && !m_reversing, (!m_linear_speed[15]) && ($unsigned(m_linear_speed) <= {1'b0, speed_limit_reg}))
    `GTG_ASSERT_IMP(a_rev_sign, aclk, aresetn, m_valid && m_reversing, m_linear_speed[15] || (m_linear_speed == 16'sd0))
    `GTG_ASSERT_NXT(a_entry_valid, aclk, aresetn, s_valid && s_ready, a_valid_reg)

endmodule

### dv/go_to_goal_drive_command_checker.sv
// Checker for the go-to-goal drive command block: predicts each drive command and compares it.
// Depends on gtg_pkg for the register codes and reset values; watches the pose, command and register channels.
`timescale 1ns / 100ps

module go_to_goal_drive_command_checker #(
    parameter int POS_FRAC_BITS = 11,
    parameter int CORDIC_STAGES = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [14:0]        s_pose_x,
    input  logic [14:0]        s_pose_y,
    input  logic signed [15:0] s_pose_heading,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_linear_speed,
    input  logic signed [15:0] m_turn_rate,
    input  logic               m_arrived,
    input  logic               m_reversing,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    output int                 mismatches,
    output int                 commands_due
);
    typedef struct packed {
        logic signed [15:0] linear_speed;
        logic signed [15:0] turn_rate;
        logic               arrived;
        logic               reversing;
    } drive_cmd_t;

    localparam longint PI_ANG   = 25736;
    localparam longint HALF_ANG = 12868;
    localparam longint UNIT_Q16 = 65536;
    localparam longint ROT_GAIN = 39797;
    localparam int     RND_SH   = 20 - POS_FRAC_BITS;

    // Arctangent of 2^-i in Q16; later stages contribute nothing.
    localparam longint ARCTAN_STEP [0:16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
        512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    logic [14:0] goal_x_q, goal_y_q, speed_limit_q, arrive_tol_q, x_band_q;
    logic [7:0]  lin_gain_q, ang_gain_q;
    drive_cmd_t  commands_pending [$];

    assign commands_due = commands_pending.size();

    function automatic longint arctan_step(int i);
        return (i <= 16) ? ARCTAN_STEP[i] : 0;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    // Work out the drive command that one pose sample should produce.
    function automatic drive_cmd_t predict_command(longint px, longint py, longint hd);
        drive_cmd_t cmd;
        longint dx, dy, dist_len, ang, cs, sn, xs, ys, ratio, vx, vy, err, lin, turn;
        logic   back;
        cmd = '0;
        if (hd > PI_ANG) hd -= 2 * PI_ANG;
        if (hd < -PI_ANG) hd += 2 * PI_ANG;
        dx = longint'(goal_x_q) - px;
        dy = longint'(goal_y_q) - py;
        dist_len = int_sqrt(dx * dx + dy * dy);
        if (dist_len < longint'(arrive_tol_q)) begin
            cmd.arrived = 1'b1;
            return cmd;
        end

        // Fold the heading into the right half plane, then rotate for sine and cosine.
        if (hd > HALF_ANG) ang = (hd - PI_ANG) * 8;
        else if (hd < -HALF_ANG) ang = (hd + PI_ANG) * 8;
        else ang = hd * 8;
        cs = ROT_GAIN;
        sn = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = cs >>> i;
            ys = sn >>> i;
            if (ang >= 0) begin
                cs -= ys; sn += xs; ang -= arctan_step(i);
            end else begin
                cs += ys; sn -= xs; ang += arctan_step(i);
            end
        end
        if (hd > HALF_ANG || hd < -HALF_ANG) begin
            cs = -cs;
            sn = -sn;
        end

        // Heading error is the arcsine of the clamped cross ratio.
        ratio = (dist_len != 0) ? (cs * dy - sn * dx) / dist_len : 0;
        if (ratio > UNIT_Q16) ratio = UNIT_Q16;
        if (ratio < -UNIT_Q16) ratio = -UNIT_Q16;
        vx = int_sqrt(UNIT_Q16 * UNIT_Q16 - ratio * ratio);
        vy = ratio;
        err = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0) begin
                vx += ys; vy -= xs; err += arctan_step(i);
            end else begin
                vx -= ys; vy += xs; err -= arctan_step(i);
            end
        end

        // Region rule around the goal decides between forward and reverse.
        if (px > longint'(goal_x_q) + longint'(x_band_q))
            back = (hd > -HALF_ANG && hd < HALF_ANG);
        else if (px < longint'(goal_x_q) - longint'(x_band_q))
            back = (hd > HALF_ANG || hd < -HALF_ANG);
        else if (py >= longint'(goal_y_q))
            back = (hd >= 0);
        else
            back = (hd < 0);

        lin = (longint'(lin_gain_q) * dist_len) / 16;
        if (lin > longint'(speed_limit_q)) lin = longint'(speed_limit_q);
        if (back) lin = -lin;
        turn = longint'(ang_gain_q) * err;
        if (RND_SH > 0) turn = (turn + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
        if (back) turn = -turn;
        if (turn > 32767) turn = 32767;
        if (turn < -32768) turn = -32768;
        cmd.linear_speed = lin[15:0];
        cmd.turn_rate    = turn[15:0];
        cmd.reversing    = back;
        return cmd;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Track register writes, predict on each pose transfer, compare each command transfer.
    always @(posedge aclk) begin
        drive_cmd_t want;
        if (!aresetn) begin
            goal_x_q      <= gtg_pkg::GOAL_X_RST;
            goal_y_q      <= gtg_pkg::GOAL_Y_RST;
            lin_gain_q    <= gtg_pkg::LIN_GAIN_RST;
            ang_gain_q    <= gtg_pkg::ANG_GAIN_RST;
            speed_limit_q <= gtg_pkg::LIMIT_RST;
            arrive_tol_q  <= gtg_pkg::TOL_RST;
            x_band_q      <= gtg_pkg::BAND_RST;
        end else begin
            if (s_valid && s_ready)
                commands_pending.push_back(predict_command(s_pose_x, s_pose_y, s_pose_heading));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gtg_pkg::REG_GOAL_X:       goal_x_q      <= cfg_data;
                    gtg_pkg::REG_GOAL_Y:       goal_y_q      <= cfg_data;
                    gtg_pkg::REG_LINEAR_GAIN:  lin_gain_q    <= cfg_data[7:0];
                    gtg_pkg::REG_ANGULAR_GAIN: ang_gain_q    <= cfg_data[7:0];
                    gtg_pkg::REG_SPEED_LIMIT:  speed_limit_q <= cfg_data;
                    gtg_pkg::REG_ARRIVE_TOL:   arrive_tol_q  <= cfg_data;
                    gtg_pkg::REG_X_BAND:       x_band_q      <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (commands_pending.size() == 0) begin
                    report_mismatch("unexpected command", 1, 0);
                end else begin
                    want = commands_pending.pop_front();
                    if (m_linear_speed !== want.linear_speed)
                        report_mismatch("linear_speed", m_linear_speed, want.linear_speed);
                    if (m_turn_rate !== want.turn_rate)
                        report_mismatch("turn_rate", m_turn_rate, want.turn_rate);
                    if (m_arrived !== want.arrived)
                        report_mismatch("arrived", m_arrived, want.arrived);
                    if (m_reversing !== want.reversing)
                        report_mismatch("reversing", m_reversing, want.reversing);
                end
            end
        end
    end

    initial mismatches = 0;

endmodule

### dv/tb_go_to_goal_drive_command_top.sv
// Testbench top for the go-to-goal drive command block: clock, reset, stimulus and verdict.
// Depends on gtg_pkg, the block itself and go_to_goal_drive_command_checker.
`timescale 1ns / 100ps

module tb_go_to_goal_drive_command_top;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int         TAIL_CYCLES = 120;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [14:0]        s_pose_x = '0;
    logic [14:0]        s_pose_y = '0;
    logic signed [15:0] s_pose_heading = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_linear_speed;
    logic signed [15:0] m_turn_rate;
    logic               m_arrived;
    logic               m_reversing;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [14:0]        cfg_data = '0;
    int                 mismatches;
    int                 commands_due;
    int                 gap_pct = 0;
    int                 stall_pct = 0;
    logic [14:0]        aim_x = '0;
    logic [14:0]        aim_y = '0;

    go_to_goal_drive_command_top u_dut (.*);

    go_to_goal_drive_command_checker u_checker (.*);

    always #5 aclk = ~aclk;

    // Command receiver stalls at the rate chosen for the phase.
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #20ms;
        $display("go_to_goal_drive_command_top verification failed");
        $finish;
    end

    // One pose transfer, followed by a random gap in which valid is low.
    task automatic send_pose(logic [14:0] px, logic [14:0] py, logic [15:0] hd);
        s_valid        <= 1'b1;
        s_pose_x       <= px;
        s_pose_y       <= py;
        s_pose_heading <= hd;
        do @(posedge aclk); while (!s_ready);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Stop sending and let every outstanding command come back.
    task automatic drain_commands();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (commands_due != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [14:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_settings(logic [14:0] gx, logic [14:0] gy, logic [7:0] lg,
                                 logic [7:0] ag, logic [14:0] lim, logic [14:0] tol,
                                 logic [14:0] band);
        drain_commands();
        write_reg(gtg_pkg::REG_GOAL_X, gx);
        write_reg(gtg_pkg::REG_GOAL_Y, gy);
        write_reg(gtg_pkg::REG_LINEAR_GAIN, {7'd0, lg});
        write_reg(gtg_pkg::REG_ANGULAR_GAIN, {7'd0, ag});
        write_reg(gtg_pkg::REG_SPEED_LIMIT, lim);
        write_reg(gtg_pkg::REG_ARRIVE_TOL, tol);
        write_reg(gtg_pkg::REG_X_BAND, band);
        aim_x = gx;
        aim_y = gy;
    endtask

    // Mostly poses near the goal so that the band, region and arrival rules all fire.
    task automatic random_poses(int count);
        int          offx, offy;
        logic [14:0] px, py;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 30) begin
                px = 15'($urandom);
                py = 15'($urandom);
            end else begin
                offx = $urandom_range(4096) - 2048;
                offy = $urandom_range(4096) - 2048;
                if ($urandom_range(9) == 0) begin
                    offx = offx / 128;
                    offy = offy / 128;
                end
                if ($urandom_range(19) == 0) begin
                    offx = 0;
                    offy = 0;
                end
                px = ((int'(aim_x) + offx) < 0) ? 15'd0 :
                     ((int'(aim_x) + offx) > 32767) ? 15'h7fff : 15'(int'(aim_x) + offx);
                py = ((int'(aim_y) + offy) < 0) ? 15'd0 :
                     ((int'(aim_y) + offy) > 32767) ? 15'h7fff : 15'(int'(aim_y) + offy);
            end
            send_pose(px, py, 16'($urandom));
            if (i == count / 2 && gap_pct == 0) drain_commands();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, arrival, headings across wrap and the half-pi edges.
        send_pose(15'd0, 15'd0, 16'h0000);
        send_pose(15'd10, 15'd5, 16'h7fff);
        send_pose(15'h7fff, 15'h7fff, 16'h8000);
        send_pose(15'h7fff, 15'd0, 16'h7fff);
        send_pose(15'd0, 15'h7fff, 16'h8000);
        send_pose(15'd3000, 15'd100, 16'd25736);
        send_pose(15'd3000, 15'd100, 16'd25737);
        send_pose(15'd3000, 15'd100, -16'sd25736);
        send_pose(15'd3000, 15'd100, -16'sd25737);
        send_pose(15'd3000, 15'd100, 16'd12868);
        send_pose(15'd3000, 15'd100, -16'sd12868);
        send_pose(15'd500, 15'd2000, 16'd0);
        send_pose(15'd500, 15'd2000, 16'hffff);
        send_pose(15'd1024, 15'd300, 16'd100);
        send_pose(15'd1025, 15'd300, 16'd100);
        send_pose(15'h5555, 15'h2aaa, 16'h5555);
        send_pose(15'h2aaa, 15'h5555, 16'haaaa);

        // Zero tolerance with the pose on the goal, and an ignored register index.
        load_settings(15'd16384, 15'd16384, 8'd96, 8'd96, 15'd16384, 15'd0, 15'd1024);
        write_reg(REG_UNUSED, 15'h7fff);
        send_pose(15'd16384, 15'd16384, 16'd1000);
        send_pose(15'd16384, 15'd16383, 16'h8000);
        send_pose(15'd16384, 15'd16385, 16'h7fff);

        // Random phases over several settings and idling mixes.
        gap_pct = 0;  stall_pct = 0;
        load_settings(15'd12000, 15'd20000, 8'd96, 8'd96, 15'd16384, 15'd20, 15'd1024);
        random_poses(220);
        gap_pct = 73; stall_pct = 0;
        load_settings(15'h7fff, 15'h7fff, 8'd255, 8'd255, 15'h7fff, 15'd1, 15'd0);
        random_poses(220);
        gap_pct = 0;  stall_pct = 73;
        load_settings(15'd0, 15'd0, 8'd0, 8'd0, 15'd0, 15'd0, 15'h7fff);
        random_poses(220);
        gap_pct = 21; stall_pct = 21;
        load_settings(15'd5000, 15'd30000, 8'd17, 8'd240, 15'd3000, 15'd200, 15'd300);
        random_poses(220);
        gap_pct = 0;  stall_pct = 0;
        load_settings(15'd20000, 15'd4000, 8'd128, 8'd1, 15'd40, 15'h7fff, 15'd2048);
        random_poses(60);
        gap_pct = 73; stall_pct = 73;
        load_settings(15'd25000, 15'd9000, 8'd64, 8'd160, 15'd20000, 15'd64, 15'd512);
        random_poses(200);
        gap_pct = 0;  stall_pct = 0;
        load_settings(15'd100, 15'd32000, 8'd200, 8'd50, 15'd8000, 15'd8, 15'd4000);
        random_poses(150);

        drain_commands();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && commands_due == 0)
            $display("go_to_goal_drive_command_top verification clean");
        else
            $display("go_to_goal_drive_command_top verification failed");
        $finish;
    end

endmodule
